FILE: rtl/core/mrh_pkg.sv
// Shared types and constants of the Mersenne rolling hash unit.
package mrh_pkg;

  localparam int MERSENNE_EXP_DEF = 61;
  localparam int HASH_W           = 61;
  localparam int SYM_W            = 32;
  localparam int FUNC_W           = 2;
  localparam int REG_IDX_W        = 1;
  localparam int QUEUE_DEPTH      = 2;

  // Operation codes, equal to the func codes of the input channel.
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_ROLL  = 2'd2;
  localparam logic [FUNC_W-1:0] OP_HOLD  = 2'd3;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BASE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DROP = 1'b1;

  // One classified item, with both symbols already reduced modulo the prime.
  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [SYM_W-1:0]  sym_in;
    logic [SYM_W-1:0]  sym_out;
  } mrh_item_t;

endpackage

FILE: rtl/core/mrh_front.sv
// Input stage: decodes the operation and reduces both symbols modulo the prime.
module mrh_front #(
  parameter int MERSENNE_EXP = mrh_pkg::MERSENNE_EXP_DEF
) (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mrh_pkg::FUNC_W-1:0] func,
  input  logic [mrh_pkg::SYM_W-1:0]  symbol_in,
  input  logic [mrh_pkg::SYM_W-1:0]  symbol_out,
  output logic                       push_valid,
  input  logic                       push_ready,
  output mrh_pkg::mrh_item_t         push_item
);
  import mrh_pkg::*;

  localparam int E = MERSENNE_EXP;
  localparam logic [E-1:0] PRIME   = '1;
  localparam logic [63:0]  PRIME64 = 64'(PRIME);

  logic [63:0] in64;
  logic [63:0] out64;
  logic [63:0] in_sum;
  logic [63:0] out_sum;
  logic [FUNC_W-1:0] op;

  // A 32-bit symbol folds once; the sum stays below twice the prime.
  assign in64    = 64'(symbol_in);
  assign out64   = 64'(symbol_out);
  assign in_sum  = (in64 & PRIME64) + (in64 >> E);
  assign out_sum = (out64 & PRIME64) + (out64 >> E);

  always_comb begin
    case (func)
      OP_CLEAR: op = OP_CLEAR;
      OP_LOAD:  op = OP_LOAD;
      OP_ROLL:  op = OP_ROLL;
      default:  op = OP_HOLD;
    endcase
  end

  assign push_item.op      = op;
  assign push_item.sym_in  = (in_sum >= PRIME64) ? 32'(in_sum - PRIME64) : 32'(in_sum);
  assign push_item.sym_out = (out_sum >= PRIME64) ? 32'(out_sum - PRIME64) : 32'(out_sum);

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

FILE: rtl/core/mrh_queue.sv
// Short queue of classified items between the input stage and the hash engine.
module mrh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mrh_pkg::mrh_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mrh_pkg::mrh_item_t pop_item
);
  import mrh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mrh_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mrh_back.sv
// Hash engine: configuration registers, hash state, modular multiply sequencer and result register.
module mrh_back #(
  parameter int MERSENNE_EXP = mrh_pkg::MERSENNE_EXP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mrh_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mrh_pkg::HASH_W-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  mrh_pkg::mrh_item_t            item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrh_pkg::HASH_W-1:0]    digest
);
  import mrh_pkg::*;

  localparam int E     = MERSENNE_EXP;
  localparam int ACC_W = 2 * E;
  localparam logic [E-1:0] PRIME    = '1;
  localparam logic [E:0]   PRIME_X  = {1'b0, PRIME};
  localparam logic [E:0]   PRIME_2X = {PRIME, 1'b0};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_RED  = 3'd4;
  localparam logic [2:0] ST_SUB  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]        state;
  logic [1:0]        cnt;
  logic              pass;
  logic [FUNC_W-1:0] op;
  logic [E-1:0]      sym_in_r;
  logic [E-1:0]      hash;
  logic [E-1:0]      base_r;
  logic [E-1:0]      drop_r;
  logic [E-1:0]      opa;
  logic [E-1:0]      opb;
  logic [63:0]       pp;
  logic [1:0]        pp_k;
  logic              pp_vld;
  logic [ACC_W-1:0]  acc;
  logic [E:0]        fsum;
  logic [E-1:0]      m;
  logic [E-1:0]      out_hash;

  logic [63:0]      a64;
  logic [63:0]      b64;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      product;
  logic [127:0]     pp_wide;
  logic [127:0]     pp_shifted;
  logic [ACC_W-1:0] acc_next;
  logic [E:0]       fold_sum;
  logic [E-1:0]     red_val;
  logic [E:0]       diff;
  logic [E:0]       fin_sum;
  logic [E-1:0]     res;
  logic [63:0]      item_in64;
  logic [63:0]      item_out64;
  logic [E:0]       cfg_fold;
  logic [E-1:0]     cfg_red;
  logic             fin_go;

  // One 32x32 partial product per cycle; cnt picks the operand halves.
  assign a64     = 64'(opa);
  assign b64     = 64'(opb);
  assign mul_a   = cnt[1] ? a64[63:32] : a64[31:0];
  assign mul_b   = cnt[0] ? b64[63:32] : b64[31:0];
  assign product = mul_a * mul_b;

  assign pp_wide = {64'd0, pp};
  always_comb begin
    case (pp_k)
      2'd0:    pp_shifted = pp_wide;
      2'd3:    pp_shifted = pp_wide << 64;
      default: pp_shifted = pp_wide << 32;
    endcase
  end
  assign acc_next = acc + pp_shifted[ACC_W-1:0];

  // Since 2^E is 1 modulo the prime, the upper half of the product adds onto the lower.
  assign fold_sum = (E+1)'(acc[E-1:0]) + (E+1)'(acc[ACC_W-1:E]);

  always_comb begin
    if (fsum >= PRIME_2X) begin
      red_val = E'(fsum - PRIME_2X);
    end else if (fsum >= PRIME_X) begin
      red_val = E'(fsum - PRIME_X);
    end else begin
      red_val = E'(fsum);
    end
  end

  // Remove the leaving symbol's weight from the hash.
  assign diff = (hash >= m) ? ({1'b0, hash} - {1'b0, m})
                            : ({1'b0, hash} + PRIME_X - {1'b0, m});

  assign fin_sum = {1'b0, m} + {1'b0, sym_in_r};
  always_comb begin
    case (op)
      OP_CLEAR: res = '0;
      OP_LOAD,
      OP_ROLL:  res = (fin_sum >= PRIME_X) ? E'(fin_sum - PRIME_X) : E'(fin_sum);
      default:  res = hash;
    endcase
  end

  assign item_in64  = 64'(item.sym_in);
  assign item_out64 = 64'(item.sym_out);

  // Register values are reduced as they are written.
  assign cfg_fold = (E+1)'(cfg_data[E-1:0]) + (E+1)'(cfg_data >> E);
  assign cfg_red  = (cfg_fold >= PRIME_X) ? E'(cfg_fold - PRIME_X) : E'(cfg_fold);

  assign fin_go     = !out_valid || out_ready;
  assign item_ready = (state == ST_IDLE);
  assign digest     = HASH_W'(out_hash);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r <= E'(256);
      drop_r <= E'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE: base_r <= cfg_red;
        REG_DROP: drop_r <= cfg_red;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pp     <= product;
    pp_k   <= cnt;
    fsum   <= fold_sum;
    if (state == ST_RED) begin
      m <= red_val;
    end
    if ((state == ST_IDLE && item_valid) || state == ST_SUB) begin
      acc <= '0;
    end else if (pp_vld) begin
      acc <= acc_next;
    end
    if (state == ST_IDLE && item_valid) begin
      op       <= item.op;
      sym_in_r <= item_in64[E-1:0];
      if (item.op == OP_ROLL) begin
        opa  <= drop_r;
        opb  <= item_out64[E-1:0];
        pass <= 1'b0;
      end else begin
        opa  <= hash;
        opb  <= base_r;
        pass <= 1'b1;
      end
    end else if (state == ST_SUB) begin
      opa  <= diff[E-1:0];
      opb  <= base_r;
      pass <= 1'b1;
    end
    if (state == ST_FIN && fin_go) begin
      out_hash <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pp_vld    <= 1'b0;
      hash      <= '0;
      out_valid <= 1'b0;
    end else begin
      pp_vld <= (state == ST_MUL);
      if (state == ST_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (item_valid) begin
            if (item.op == OP_LOAD || item.op == OP_ROLL) begin
              state <= ST_MUL;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          state <= ST_FOLD;
        end
        ST_FOLD: begin
          state <= ST_RED;
        end
        ST_RED: begin
          state <= pass ? ST_FIN : ST_SUB;
        end
        ST_SUB: begin
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_FIN: begin
          if (fin_go) begin
            hash  <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/mersenne_rolling_hash_unit.sv
// Karp-Rabin rolling hash modulo 2^MERSENNE_EXP - 1: clear, load one symbol, or roll the window.
// In the hash engine a load forms one modular product and a roll two in sequence; a clear or
// an unused operation code forms none. The engine has a single 32x32 multiplier, which
// builds each modular product from four partial products, followed by accumulate, fold and
// reduce steps. Items are handled one at a time, while a two-entry input queue and the
// result register let the input and output sides stall on their own. Both configuration
// registers are reduced modulo the prime as they are written and may only be written while
// the unit is idle.
module mersenne_rolling_hash_unit #(
  parameter int MERSENNE_EXP = mrh_pkg::MERSENNE_EXP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mrh_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mrh_pkg::HASH_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mrh_pkg::FUNC_W-1:0]    func,
  input  logic [mrh_pkg::SYM_W-1:0]     symbol_in,
  input  logic [mrh_pkg::SYM_W-1:0]     symbol_out,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrh_pkg::HASH_W-1:0]    digest
);
  import mrh_pkg::*;

  logic      push_valid;
  logic      push_ready;
  mrh_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  mrh_item_t pop_item;

  mrh_front #(
    .MERSENNE_EXP(MERSENNE_EXP)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .symbol_in (symbol_in),
    .symbol_out(symbol_out),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  mrh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  mrh_back #(
    .MERSENNE_EXP(MERSENNE_EXP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_valid(pop_valid),
    .item_ready(pop_ready),
    .item      (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digest    (digest)
  );

endmodule

FILE: bench/mersenne_rolling_hash_unit_test.sv
// Self-checking testbench of the Mersenne rolling hash unit with a bit-exact hash predictor.
module mersenne_rolling_hash_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mrh_pkg::*;

  localparam logic [HASH_W-1:0] PRIME = {HASH_W{1'b1}};
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS   = 90;
  localparam int RANDOM_PHASES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [HASH_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func = OP_CLEAR;
  logic [SYM_W-1:0]     symbol_in = '0;
  logic [SYM_W-1:0]     symbol_out = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HASH_W-1:0]    digest;

  mersenne_rolling_hash_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .symbol_in  (symbol_in),
    .symbol_out (symbol_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest     (digest)
  );

  always #5 clk = ~clk;

  // Predictor state and register copies, at their reset values.
  logic [HASH_W-1:0] model_hash = '0;
  logic [HASH_W-1:0] model_base = HASH_W'(256);
  logic [HASH_W-1:0] model_drop = HASH_W'(1);

  mrh_item_t         pending_items[$];
  logic [HASH_W-1:0] expected_hashes[$];
  int                queued_items = 0;
  int                errors = 0;
  int                hold_requests = 0;
  int                holds_done = 0;
  int                gap_left = 0;
  int                stall_left = 0;
  int                send_run = 0;
  bit                send_calm = 1'b0;
  int                recv_run = 0;
  bit                recv_calm = 1'b0;

  function automatic logic [HASH_W-1:0] mod_prime(input logic [2*HASH_W-1:0] x);
    logic [2*HASH_W-1:0] s;
    s = x[HASH_W-1:0] + (x >> HASH_W);
    s = s[HASH_W-1:0] + (s >> HASH_W);
    if (s >= PRIME) s = s - PRIME;
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
    logic [2*HASH_W-1:0] prod;
    prod = {{HASH_W{1'b0}}, a} * {{HASH_W{1'b0}}, b};
    return mod_prime(prod);
  endfunction

  function automatic logic [HASH_W-1:0] next_hash(input logic [HASH_W-1:0] h,
                                                  input logic [FUNC_W-1:0] op,
                                                  input logic [SYM_W-1:0]  sin,
                                                  input logic [SYM_W-1:0]  sout,
                                                  input logic [HASH_W-1:0] base_reg,
                                                  input logic [HASH_W-1:0] drop_reg);
    logic [HASH_W-1:0] b;
    logic [HASH_W-1:0] d;
    logic [HASH_W-1:0] removed;
    logic [HASH_W-1:0] t;
    b = mod_prime(base_reg);
    d = mod_prime(drop_reg);
    case (op)
      OP_CLEAR: return '0;
      OP_LOAD:  return mod_prime(mul_prime(h, b) + sin);
      OP_ROLL: begin
        removed = mul_prime(d, {{(HASH_W-SYM_W){1'b0}}, sout});
        t = mod_prime({{HASH_W{1'b0}}, h} + PRIME - removed);
        return mod_prime(mul_prime(t, b) + sin);
      end
      default:  return h;
    endcase
  endfunction

  // Each run of handshakes is either calm, with no waits, or has random waits; one run in four is calm.
  function automatic int next_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    run_left = run_left - 1;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [SYM_W-1:0] draw_symbol();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HASH_W-1:0] draw_wide();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[HASH_W-1:0];
  endfunction

  always @(posedge clk) begin : driver
    int g;
    mrh_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        model_hash = next_hash(model_hash, func, symbol_in, symbol_out, model_base, model_drop);
        expected_hashes.push_back(model_hash);
        g = next_wait(send_run, send_calm);
      end else begin
        g = gap_left;
      end
      if (!in_valid || in_ready) begin
        if (g != 0) begin
          gap_left <= g - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          func       <= it.op;
          symbol_in  <= it.sym_in;
          symbol_out <= it.sym_out;
          in_valid   <= 1'b1;
          gap_left   <= 0;
        end else begin
          in_valid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    int s;
    logic [HASH_W-1:0] want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, digest);
          errors++;
        end else begin
          want = expected_hashes.pop_front();
          if (digest !== want) begin
            $display("%0t: digest mismatch, expected %h, actual %h", $time, want, digest);
            errors++;
          end
        end
      end
      if (holds_done != hold_requests) begin
        // Long hold-off so the input queue fills and in_ready drops.
        holds_done <= hold_requests;
        stall_left <= HOLD_CYCLES - 1;
        out_ready  <= 1'b0;
      end else begin
        if (out_valid && out_ready) s = next_wait(recv_run, recv_calm);
        else s = stall_left;
        if (s != 0) begin
          stall_left <= s - 1;
          out_ready  <= 1'b0;
        end else begin
          stall_left <= 0;
          out_ready  <= 1'b1;
        end
      end
    end
  end

  task automatic push(input logic [FUNC_W-1:0] op, input logic [SYM_W-1:0] sin,
                      input logic [SYM_W-1:0] sout);
    mrh_item_t it;
    it.op      = op;
    it.sym_in  = sin;
    it.sym_out = sout;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [HASH_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_BASE) model_base = val;
    else model_drop = val;
  endtask

  // Returns once every item has been transferred, every hash has come back and a further settle wait is over.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_hashes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_both(input logic [HASH_W-1:0] b, input logic [HASH_W-1:0] d);
    settle();
    write_reg(REG_BASE, b);
    write_reg(REG_DROP, d);
    @(negedge clk);
  endtask

  initial begin : sequencer
    int ph;
    int w;
    int k;
    int n;
    int start;
    logic [HASH_W-1:0] b;
    logic [HASH_W-1:0] d;
    logic [SYM_W-1:0]  s;
    logic [SYM_W-1:0]  window[$];
    logic [FUNC_W-1:0] op;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: unused code on the reset hash, symbol extremes, ignored symbol_out,
    // and a roll on a zero hash that wraps the subtraction.
    push(OP_HOLD, '1, '1);
    push(OP_LOAD, '0, '1);
    push(OP_LOAD, '1, '0);
    push(OP_LOAD, 32'h1234_5678, 32'hDEAD_BEEF);
    push(OP_ROLL, '0, '0);
    push(OP_ROLL, '1, '1);
    push(OP_HOLD, '0, '0);
    push(OP_CLEAR, '1, '1);
    push(OP_ROLL, 32'd5, '1);
    push(OP_LOAD, 32'h41, '0);

    // Largest operands below the prime.
    write_both(PRIME - 1'b1, PRIME - 1'b1);
    push(OP_LOAD, '1, '0);
    push(OP_LOAD, '1, '1);
    push(OP_LOAD, '1, '0);
    push(OP_ROLL, '1, '1);
    push(OP_ROLL, '0, '1);
    push(OP_HOLD, '1, '0);

    // Registers equal to the prime act as zero.
    write_both(PRIME, PRIME);
    push(OP_LOAD, 32'd7, '0);
    push(OP_ROLL, 32'd9, '1);
    push(OP_ROLL, '1, '1);
    push(OP_CLEAR, '0, '0);

    write_both(HASH_W'(1), '0);
    push(OP_LOAD, '1, '0);
    push(OP_ROLL, 32'd1, '1);
    push(OP_LOAD, '0, '0);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      b = draw_wide();
      if (ph == 2) b = HASH_W'($urandom_range(2, 1000));
      if (ph == 5) b = PRIME - 1'b1;
      if (ph == 6) b = HASH_W'(1);
      if (b == '0) b = HASH_W'(256);
      w = $urandom_range(1, 8);
      // Drop factor of a real window: base to the power window minus one.
      d = HASH_W'(1);
      for (k = 1; k < w; k++) d = mul_prime(d, mod_prime(b));
      if (ph == 3) d = draw_wide();
      if (ph == 7) d = PRIME;
      write_both(b, d);
      if (ph == 1 || ph == 4) hold_requests++;
      start = queued_items;
      while (queued_items - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          push(OP_CLEAR, draw_symbol(), draw_symbol());
          window.delete();
          for (k = 0; k < w; k++) begin
            s = draw_symbol();
            push(OP_LOAD, s, draw_symbol());
            window.push_back(s);
          end
          n = $urandom_range(1, 30);
          for (k = 0; k < n; k++) begin
            s = draw_symbol();
            push(OP_ROLL, s, window.pop_front());
            window.push_back(s);
          end
        end else begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
              0: op = OP_CLEAR;
              1: op = OP_LOAD;
              2: op = OP_ROLL;
              default: op = OP_HOLD;
            endcase
            push(op, draw_symbol(), draw_symbol());
          end
        end
      end
    end

    settle();
    if (errors == 0 && expected_hashes.size() == 0) begin
      $display("PASS mersenne_rolling_hash_unit");
    end else begin
      $display("FAIL mersenne_rolling_hash_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL mersenne_rolling_hash_unit");
    $finish;
  end

endmodule
